FILE: design/qpr_pkg.sv
// shared component indexes and item kind codes for the quaternion core
package qpr_pkg;

    localparam int unsigned QW = 0;
    localparam int unsigned QX = 1;
    localparam int unsigned QY = 2;
    localparam int unsigned QZ = 3;

    localparam logic KIND_MUL = 1'b0;
    localparam logic KIND_ROT = 1'b1;

endpackage

FILE: design/qpr_qmul.sv
// three-stage pipelined hamilton product with rounding, clamping and a sideband
module qpr_qmul
    import qpr_pkg::*;
#(
    parameter int DW = 16,
    parameter int FW = 14,
    parameter int OW = 17,
    parameter int SW = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [OW-1:0] p [4],
    input  logic signed [OW-1:0] q [4],
    input  logic        [SW-1:0] in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DW-1:0] r [4],
    output logic        [3:0]    sat,
    output logic        [SW-1:0] out_side
);

    localparam int PW    = 2 * OW;
    localparam int PAIRW = PW + 2;
    localparam int SUMW  = PW + 3;
    localparam logic signed [SUMW-1:0] HALF  = SUMW'(1) << (FW - 1);
    localparam logic signed [SUMW-1:0] MAX_V = (SUMW'(1) << (DW - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] MIN_V = ~MAX_V;

    logic                    v1_reg, v2_reg, v3_reg;
    logic                    en1, en2, en3;
    logic signed [PW-1:0]    prod_reg [16];
    logic signed [PW-1:0]    prod_next [16];
    logic signed [PAIRW-1:0] pa_reg [4];
    logic signed [PAIRW-1:0] pb_reg [4];
    logic signed [PAIRW-1:0] pa_next [4];
    logic signed [PAIRW-1:0] pb_next [4];
    logic signed [DW-1:0]    r_reg [4];
    logic signed [DW-1:0]    r_next [4];
    logic        [3:0]       sat_reg, sat_next;
    logic        [SW-1:0]    side1_reg, side2_reg, side3_reg;

    // a stage moves on when empty or when the next one moves
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[4*i+j] = p[i] * q[j];
            end
        end
    end

    // prod index is 4*i+j for p[i]*q[j]
    always_comb
    begin
        pa_next[QW] = PAIRW'(prod_reg[4*QW+QW]) - PAIRW'(prod_reg[4*QX+QX]);
        pb_next[QW] = -PAIRW'(prod_reg[4*QY+QY]) - PAIRW'(prod_reg[4*QZ+QZ]);
        pa_next[QX] = PAIRW'(prod_reg[4*QW+QX]) + PAIRW'(prod_reg[4*QX+QW]);
        pb_next[QX] = PAIRW'(prod_reg[4*QY+QZ]) - PAIRW'(prod_reg[4*QZ+QY]);
        pa_next[QY] = PAIRW'(prod_reg[4*QW+QY]) + PAIRW'(prod_reg[4*QY+QW]);
        pb_next[QY] = PAIRW'(prod_reg[4*QZ+QX]) - PAIRW'(prod_reg[4*QX+QZ]);
        pa_next[QZ] = PAIRW'(prod_reg[4*QW+QZ]) + PAIRW'(prod_reg[4*QZ+QW]);
        pb_next[QZ] = PAIRW'(prod_reg[4*QX+QY]) - PAIRW'(prod_reg[4*QY+QX]);
    end

    always_comb
    begin
        logic signed [SUMW-1:0] full;
        logic signed [SUMW-1:0] rnd;
        for (int c = 0; c < 4; c++)
        begin
            // round half up once, then clamp
            full = SUMW'(pa_reg[c]) + SUMW'(pb_reg[c]) + HALF;
            rnd  = full >>> FW;
            if (rnd > MAX_V)
            begin
                r_next[c]   = MAX_V[DW-1:0];
                sat_next[c] = 1'b1;
            end
            else if (rnd < MIN_V)
            begin
                r_next[c]   = MIN_V[DW-1:0];
                sat_next[c] = 1'b1;
            end
            else
            begin
                r_next[c]   = rnd[DW-1:0];
                sat_next[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg  <= prod_next;
            side1_reg <= in_side;
        end
        if (en2)
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            side2_reg <= side1_reg;
        end
        if (en3)
        begin
            r_reg     <= r_next;
            sat_reg   <= sat_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign r         = r_reg;
    assign sat       = sat_reg;
    assign out_side  = side3_reg;

endmodule

FILE: design/quaternion_product_and_rotate_core.sv
// top level: quaternion product and vector rotation stream core
// Takes one beat per clock while s_tready is high and returns one result beat per input beat,
// in order. There are six register stages, and each beat passes through all of them before
// m_tvalid rises. The stages are those of two chained three-stage multiply units (products,
// pair sums, final sum with rounding and clamp); the first forms A*B or A*(0,v), the second
// t*conj(A), and the result for a product beat skips the second unit's value. Every stage
// holds its own valid bit, so empty stages fill while m_tready is low and s_tready drops only
// when all are full. Values are signed fixed point with FRAC_BITS fraction bits, each
// component rounded half up and clamped; the saturated flag reports any clamp of an output
// component, including the rotation's intermediate quaternion.
module quaternion_product_and_rotate_core
    import qpr_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, zero fill
    input  logic [((8*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
    // kind
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // r_w, r_x, r_y, r_z, zero fill
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
    // saturated
    output logic [0:0]                             m_tuser
);

    localparam int DW   = DATA_WIDTH;
    localparam int OW   = DATA_WIDTH + 1;
    localparam int SW1  = 1 + 4 * DW;
    localparam int SW2  = 2 + 4 * DW;
    localparam int OUTW = ((4*DATA_WIDTH+7)/8)*8;

    logic signed [DW-1:0] a [4];
    logic signed [DW-1:0] b [4];
    logic signed [OW-1:0] p1 [4];
    logic signed [OW-1:0] q1 [4];
    logic signed [OW-1:0] p2 [4];
    logic signed [OW-1:0] q2 [4];
    logic signed [DW-1:0] t [4];
    logic signed [DW-1:0] r2 [4];
    logic signed [DW-1:0] ta [4];
    logic signed [DW-1:0] a1 [4];
    logic [3:0]           sat1, sat2;
    logic [SW1-1:0]       side1_in, side1_out;
    logic [SW2-1:0]       side2_in, side2_out;
    logic                 v1_out, r1_in;
    logic                 kind1, kind2, tsat2;
    logic [4*DW-1:0]      res;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a[i]  = s_tdata[i*DW +: DW];
            b[i]  = s_tdata[(4+i)*DW +: DW];
            p1[i] = OW'(a[i]);
            q1[i] = OW'(b[i]);
        end
        // rotation works on the pure quaternion (0, v)
        if (s_tuser[0] == KIND_ROT)
        begin
            q1[QW] = '0;
        end
        side1_in = {s_tuser[0], s_tdata[4*DW-1:0]};
    end

    qpr_qmul #(
        .DW (DW),
        .FW (FRAC_BITS),
        .OW (OW),
        .SW (SW1)
    ) u_pass1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .p         (p1),
        .q         (q1),
        .in_side   (side1_in),
        .out_valid (v1_out),
        .out_ready (r1_in),
        .r         (t),
        .sat       (sat1),
        .out_side  (side1_out)
    );

    always_comb
    begin
        kind1 = side1_out[SW1-1];
        for (int i = 0; i < 4; i++)
        begin
            a1[i] = side1_out[i*DW +: DW];
            p2[i] = OW'(t[i]);
            // exact negation: the extra bit keeps the most negative value from wrapping
            q2[i] = (i == QW) ? OW'(a1[i]) : -OW'(a1[i]);
        end
        side2_in = {kind1, |sat1, t[QZ], t[QY], t[QX], t[QW]};
    end

    qpr_qmul #(
        .DW (DW),
        .FW (FRAC_BITS),
        .OW (OW),
        .SW (SW2)
    ) u_pass2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_out),
        .in_ready  (r1_in),
        .p         (p2),
        .q         (q2),
        .in_side   (side2_in),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .r         (r2),
        .sat       (sat2),
        .out_side  (side2_out)
    );

    always_comb
    begin
        kind2 = side2_out[SW2-1];
        tsat2 = side2_out[SW2-2];
        for (int i = 0; i < 4; i++)
        begin
            ta[i] = side2_out[i*DW +: DW];
        end
        if (kind2 == KIND_ROT)
        begin
            res        = {r2[QZ], r2[QY], r2[QX], {DW{1'b0}}};
            m_tuser[0] = tsat2 | sat2[QX] | sat2[QY] | sat2[QZ];
        end
        else
        begin
            res        = {ta[QZ], ta[QY], ta[QX], ta[QW]};
            m_tuser[0] = tsat2;
        end
        m_tdata = OUTW'(res);
    end

endmodule

FILE: bench/quaternion_product_and_rotate_core_tb.sv
// testbench for the quaternion product and vector rotation stream core
module quaternion_product_and_rotate_core_tb;
    import qpr_pkg::*;

    localparam int DW   = 16;
    localparam int FRAC = 14;
    localparam longint QMAX = (longint'(1) << (DW - 1)) - 1;
    localparam longint QMIN = -QMAX - 1;

    typedef struct packed {
        logic               kind;
        logic [3:0][DW-1:0] b;
        logic [3:0][DW-1:0] a;
    } quat_item_t;

    typedef struct packed {
        logic               sat;
        logic [3:0][DW-1:0] r;
    } quat_result_t;

    typedef struct packed {
        logic               sat_s;
        logic               sat_v;
        logic [3:0][DW-1:0] q;
    } hamilton_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    quat_result_t pending_results[$];
    quat_result_t want;
    int           error_count = 0;
    bit           src_idle_on = 1'b1;
    bit           sink_idle_on = 1'b1;
    int           sink_stall_left = 0;
    string        rname[4] = '{"r_w", "r_x", "r_y", "r_z"};

    quaternion_product_and_rotate_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // round half up once, then clamp; top bit of the return is the clamp flag
    function automatic logic [DW:0] round_clamp(input longint acc);
        longint v;
        v = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (v > QMAX)
            return {1'b1, DW'(QMAX)};
        if (v < QMIN)
            return {1'b1, DW'(QMIN)};
        return {1'b0, DW'(v)};
    endfunction

    // hamilton product p*q, optionally with the exact conjugate of q
    function automatic hamilton_t hamilton(input logic [3:0][DW-1:0] p,
                                           input logic [3:0][DW-1:0] q,
                                           input bit conj_q);
        longint    pw, px, py, pz, qw, qx, qy, qz;
        longint    acc[4];
        logic [DW:0] rc;
        hamilton_t res;
        pw = $signed(p[QW]);
        px = $signed(p[QX]);
        py = $signed(p[QY]);
        pz = $signed(p[QZ]);
        qw = $signed(q[QW]);
        qx = $signed(q[QX]);
        qy = $signed(q[QY]);
        qz = $signed(q[QZ]);
        if (conj_q)
        begin
            qx = -qx;
            qy = -qy;
            qz = -qz;
        end
        acc[QW] = pw * qw - px * qx - py * qy - pz * qz;
        acc[QX] = pw * qx + qw * px + py * qz - pz * qy;
        acc[QY] = pw * qy + qw * py + pz * qx - px * qz;
        acc[QZ] = pw * qz + qw * pz + px * qy - py * qx;
        res.sat_v = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            rc = round_clamp(acc[i]);
            res.q[i] = rc[DW-1:0];
            if (i == QW)
                res.sat_s = rc[DW];
            else
                res.sat_v = res.sat_v | rc[DW];
        end
        return res;
    endfunction

    function automatic quat_result_t quat_core_result(input quat_item_t it);
        logic [3:0][DW-1:0] pure_q;
        hamilton_t          t;
        hamilton_t          u;
        quat_result_t       res;
        if (it.kind == KIND_MUL)
        begin
            t = hamilton(it.a, it.b, 1'b0);
            res.r = t.q;
            res.sat = t.sat_s | t.sat_v;
        end
        else
        begin
            pure_q = it.b;
            pure_q[QW] = '0;
            t = hamilton(it.a, pure_q, 1'b0);
            u = hamilton(t.q, it.a, 1'b1);
            res.r = u.q;
            // scalar of the second product is dropped and never flags
            res.r[QW] = '0;
            res.sat = t.sat_s | t.sat_v | u.sat_v;
        end
        return res;
    endfunction

    function automatic quat_item_t make_item(input logic kind,
                                             input int aw, input int ax, input int ay,
                                             input int az, input int bw, input int bx,
                                             input int by, input int bz);
        quat_item_t it;
        it.kind = kind;
        it.a[QW] = DW'(aw);
        it.a[QX] = DW'(ax);
        it.a[QY] = DW'(ay);
        it.a[QZ] = DW'(az);
        it.b[QW] = DW'(bw);
        it.b[QX] = DW'(bx);
        it.b[QY] = DW'(by);
        it.b[QZ] = DW'(bz);
        return it;
    endfunction

    function automatic logic [DW-1:0] rand_field(input int mode);
        case (mode)
            0: return DW'($urandom);
            1: return DW'(int'($urandom_range(0, 32768)) - 16384);
            default:
            begin
                case ($urandom_range(0, 6))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    4: return 16'h4000;
                    5: return 16'hc000;
                    default: return DW'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic quat_item_t rand_item();
        quat_item_t it;
        int         mode;
        real        w, x, y, z, n;
        it.kind = $urandom_range(0, 1) ? KIND_ROT : KIND_MUL;
        mode = $urandom_range(0, 9);
        if (mode >= 7)
        begin
            // unit-length A, the case a real rotation sees
            w = $urandom_range(0, 2000) - 1000.0;
            x = $urandom_range(0, 2000) - 1000.0;
            y = $urandom_range(0, 2000) - 1000.0;
            z = $urandom_range(0, 2000) - 1000.0;
            n = $sqrt(w * w + x * x + y * y + z * z);
            if (n < 1.0)
            begin
                w = 1.0;
                n = 1.0;
            end
            it.a[QW] = DW'($rtoi(w / n * 16383.0));
            it.a[QX] = DW'($rtoi(x / n * 16383.0));
            it.a[QY] = DW'($rtoi(y / n * 16383.0));
            it.a[QZ] = DW'($rtoi(z / n * 16383.0));
            for (int i = 0; i < 4; i++)
                it.b[i] = rand_field(1);
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                it.a[i] = rand_field(mode < 3 ? 0 : (mode < 5 ? 1 : 2));
                it.b[i] = rand_field(mode < 3 ? 0 : (mode < 5 ? 1 : 2));
            end
        end
        return it;
    endfunction

    task automatic send_quat(input quat_item_t it);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge clk);
        end
        s_tdata = {it.b, it.a};
        s_tuser = it.kind;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(quat_core_result(it));
        @(negedge clk);
    endtask

    task automatic test_products_directed();
        send_quat(make_item(KIND_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0));
        send_quat(make_item(KIND_MUL, 0, 16384, 0, 0, 0, 0, 16384, 0));
        send_quat(make_item(KIND_MUL, 0, 0, 16384, 0, 0, 16384, 0, 0));
        send_quat(make_item(KIND_MUL, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767));
        send_quat(make_item(KIND_MUL, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768));
        send_quat(make_item(KIND_MUL, 32767, -32768, 32767, -32768,
                            -32768, 32767, -32768, 32767));
        send_quat(make_item(KIND_MUL, 0, 0, 0, 0, 0, 0, 0, 0));
        // exact halves round up, both signs
        send_quat(make_item(KIND_MUL, 1, 0, 0, 0, 8192, -8192, 8191, -8193));
        send_quat(make_item(KIND_MUL, -1, 0, 0, 0, 8192, -8192, 24576, -24576));
        send_quat(make_item(KIND_MUL, 21845, -21846, 21845, -21846,
                            -21846, 21845, -21846, 21845));
    endtask

    task automatic test_rotations_directed();
        send_quat(make_item(KIND_ROT, 16384, 0, 0, 0, 0, 16384, -16384, 8192));
        // quarter turn about z, scalar of B must not matter
        send_quat(make_item(KIND_ROT, 11585, 0, 0, 11585, 32767, 16384, 0, 0));
        send_quat(make_item(KIND_ROT, 11585, 0, 0, 11585, -32768, 16384, 0, 0));
        send_quat(make_item(KIND_ROT, 0, 16384, 0, 0, -32768, 0, 16384, -32768));
        send_quat(make_item(KIND_ROT, -32768, -32768, -32768, -32768,
                            0, -32768, -32768, -32768));
        send_quat(make_item(KIND_ROT, 32767, 32767, 32767, 32767,
                            0, 32767, -32768, 32767));
        // most negative vector part in A, conjugate must not wrap
        send_quat(make_item(KIND_ROT, 0, -32768, 0, 0, 0, 16384, 16384, 16384));
        send_quat(make_item(KIND_ROT, 0, 0, -32768, -32768, 0, 1, -1, 8192));
        send_quat(make_item(KIND_ROT, 0, 0, 0, 0, 0, 0, 0, 0));
        send_quat(make_item(KIND_ROT, -21846, 21845, -21846, 21845,
                            21845, -21846, 21845, -21846));
    endtask

    task automatic test_random_mixed(input int count);
        for (int n = 0; n < count; n++)
            send_quat(rand_item());
    endtask

    task automatic test_drain_pause();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_random_back_to_back(input int count);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        for (int n = 0; n < count; n++)
            send_quat(rand_item());
    endtask

    // receiver stalls in bursts
    always @(negedge clk)
    begin
        if (sink_stall_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0)
            sink_stall_left = $urandom_range(1, 16);
        if (sink_stall_left > 0)
        begin
            m_tready = 1'b0;
            sink_stall_left = sink_stall_left - 1;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (m_tdata[DW*i +: DW] !== want.r[i])
                    begin
                        $error("%s expected %0d actual %0d", rname[i],
                               $signed(want.r[i]), $signed(m_tdata[DW*i +: DW]));
                        error_count++;
                    end
                end
                if (m_tuser[0] !== want.sat)
                begin
                    $error("saturated expected %0d actual %0d", want.sat, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_products_directed();
        test_rotations_directed();
        test_random_mixed(700);
        test_drain_pause();
        test_random_mixed(650);
        test_random_back_to_back(580);

        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("quaternion_product_and_rotate_core verification clean");
        else
            $display("quaternion_product_and_rotate_core verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("quaternion_product_and_rotate_core verification failed");
        $finish;
    end

endmodule
